/* rtl/core/hdzs_pkg.sv */
// ----------------------------------------------------------------------------
// hdzs_pkg
// Shared types, constants and lookup functions of the date header parser:
// result status codes, the parse record passed from front to back, the
// month name decoder and the month length table.
// ----------------------------------------------------------------------------
package hdzs_pkg;

  // Default number of parse records held between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Hour offset after reset
  localparam logic [4:0] OFFSET_RESET = 5'd8;

  // Hours in one day
  localparam logic [7:0] HOURS_PER_DAY = 8'd24;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_PREFIX  = 2'd1,
    ST_BAD_FORMAT = 2'd2,
    ST_BAD_MONTH  = 2'd3
  } stat_e;

  // One finished parse; ST_OK here means the month is still to be decoded
  typedef struct packed {
    stat_e       status;
    logic [23:0] mtext;
    logic [6:0]  yhi;      // century digits of the year
    logic [6:0]  ylo;      // last two digits of the year
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [4:0]  offset;
  } rec_t;

  // Decode a three-letter month name; zero when unknown
  function automatic logic [3:0] month_decode(input logic [23:0] mtext);
    logic [3:0] mon;
    case (mtext)
      "Jan":   mon = 4'd1;
      "Feb":   mon = 4'd2;
      "Mar":   mon = 4'd3;
      "Apr":   mon = 4'd4;
      "May":   mon = 4'd5;
      "Jun":   mon = 4'd6;
      "Jul":   mon = 4'd7;
      "Aug":   mon = 4'd8;
      "Sep":   mon = 4'd9;
      "Oct":   mon = 4'd10;
      "Nov":   mon = 4'd11;
      "Dec":   mon = 4'd12;
      default: mon = 4'd0;
    endcase
    return mon;
  endfunction

  // Days in a month, February following the leap flag
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] days;
    case (mon)
      4'd2:    days = leap ? 5'd29 : 5'd28;
      4'd4:    days = 5'd30;
      4'd6:    days = 5'd30;
      4'd9:    days = 5'd30;
      4'd11:   days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

/* rtl/core/http_date_parse_zone_shift.sv */
// ----------------------------------------------------------------------------
// http_date_parse_zone_shift
// Streaming parser of a "Date:" header line with an hour offset applied.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on the in_* channel (valid/ready), one byte per cycle,
//   last_i marking the final byte of a buffer. A zero byte ends the text;
//   bytes after it are dropped until the byte marked last.
//   One result per buffer leaves on the out_* channel (valid/ready): status,
//   and the date and time shifted by hour_offset, all zero on error.
//   hour_offset is written on the cfg_* channel, always ready. The user must write
//   it only while the block is idle; the block does not enforce it. It resets to 8.
//   Throughput: one byte per cycle. The byte parser never waits for the
//   result unit except when the record queue is full.
//   Result path: the result unit decodes the month, then walks the calendar
//   one day per cycle for each day carry (at most 5) before it loads the
//   result register.
//   Reset clears the parser control state, the queue and the result valid flag.
//   When the receiver stalls, the result register holds, queued records
//   wait, and input is refused only once the queue is full.
// ----------------------------------------------------------------------------
module http_date_parse_zone_shift #(
  parameter int unsigned QueueDepth = hdzs_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  hour_offset_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [6:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [6:0]  minute_o,
  output logic [6:0]  second_o
);

  logic [4:0]     offset_q;
  logic           q_push, q_pop, q_full, q_empty;
  hdzs_pkg::rec_t q_wr_rec, q_rd_rec;

  // Offset register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= hdzs_pkg::OFFSET_RESET;
    end else if (cfg_valid_i) begin
      offset_q <= hour_offset_i;
    end
  end

  hdzs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .offset_i    (offset_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (q_wr_rec)
  );

  hdzs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_wr_rec),
    .pop_i   (q_pop),
    .rec_o   (q_rd_rec),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hdzs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (q_rd_rec),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .year_o      (year_o),
    .month_o     (month_o),
    .day_o       (day_o),
    .hour_o      (hour_o),
    .minute_o    (minute_o),
    .second_o    (second_o)
  );

endmodule

/* rtl/core/hdzs_front.sv */
// ----------------------------------------------------------------------------
// hdzs_front
// Byte parser: finds the first "Date:" and walks the header format one byte
// per cycle unless the queue is full; a zero or final byte pushes one record.
// ----------------------------------------------------------------------------
module hdzs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_i,
  input  logic [4:0]        offset_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output hdzs_pkg::rec_t    q_rec_o
);

  typedef enum logic [12:0] {
    PH_SEARCH = 13'b0000000000001,
    PH_WEEK   = 13'b0000000000010,
    PH_COMMA  = 13'b0000000000100,
    PH_DAY    = 13'b0000000001000,
    PH_MON    = 13'b0000000010000,
    PH_YEAR   = 13'b0000000100000,
    PH_HOUR   = 13'b0000001000000,
    PH_COLON1 = 13'b0000010000000,
    PH_MIN    = 13'b0000100000000,
    PH_COLON2 = 13'b0001000000000,
    PH_SEC    = 13'b0010000000000,
    PH_DONE   = 13'b0100000000000,
    PH_BAD    = 13'b1000000000000
  } phase_e;

  phase_e      phase_q, phase_d, ph_f, ph_p;
  logic [2:0]  prefix_q, prefix_d, pre_f;
  logic [1:0]  tok_q, tok_d, tok_f;
  logic [23:0] mtext_q, mtext_d, mt_f, mt_p;
  logic [2:0]  dc_q, dc_d, dc_f, dc_p;
  logic [6:0]  yhi_q, yhi_d, yhi_f, yhi_p;
  logic [6:0]  ylo_q, ylo_d, ylo_f, ylo_p;
  logic [6:0]  day_q, day_d, day_f, day_p;
  logic [6:0]  hour_q, hour_d, hour_f, hour_p;
  logic [6:0]  min_q, min_d, min_f, min_p;
  logic [6:0]  sec_q, sec_d, sec_f, sec_p;
  logic        ended_q, ended_d;

  logic        accept, is_zero, is_ws, is_dig;
  logic [3:0]  dval;
  logic [2:0]  need;
  logic        num_take, num_fin, num_bad, num_first;
  logic [6:0]  acc_cur, acc_new;
  logic [7:0]  pre_char;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_zero    = (data_byte_i == 8'h00);
  assign is_ws      = (data_byte_i == 8'h20) || (data_byte_i >= 8'h09 && data_byte_i <= 8'h0D);
  assign is_dig     = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign dval       = data_byte_i[3:0];

  // Expected prefix character
  always_comb begin
    case (prefix_q)
      3'd0:    pre_char = "D";
      3'd1:    pre_char = "a";
      3'd2:    pre_char = "t";
      3'd3:    pre_char = "e";
      default: pre_char = ":";
    endcase
  end

  // Classify the byte against the number rules of the current field
  always_comb begin
    need      = (phase_q == PH_YEAR) ? 3'd4 : 3'd2;
    num_take  = 1'b0;
    num_fin   = 1'b0;
    num_bad   = 1'b0;
    if (dc_q == 3'd0) begin
      if (!is_ws) begin
        if (is_dig) num_take = 1'b1;
        else        num_bad  = 1'b1;
      end
    end else if (dc_q < need) begin
      if (is_dig) num_take = 1'b1;
      else        num_bad  = 1'b1;
    end else begin
      if (is_dig) num_bad = 1'b1;
      else        num_fin = 1'b1;
    end
    num_first = (dc_q == 3'd0) || ((phase_q == PH_YEAR) && (dc_q == 3'd2));
    case (phase_q)
      PH_DAY:  acc_cur = day_q;
      PH_YEAR: acc_cur = (dc_q < 3'd2) ? yhi_q : ylo_q;
      PH_HOUR: acc_cur = hour_q;
      PH_MIN:  acc_cur = min_q;
      PH_SEC:  acc_cur = sec_q;
      default: acc_cur = 7'd0;
    endcase
    acc_new = num_first ? {3'd0, dval} : 7'(acc_cur * 7'd10 + {3'd0, dval});
  end

  // Advance the parse by one non-zero byte
  always_comb begin
    ph_f   = phase_q;
    pre_f  = prefix_q;
    tok_f  = tok_q;
    mt_f   = mtext_q;
    dc_f   = dc_q;
    yhi_f  = yhi_q;
    ylo_f  = ylo_q;
    day_f  = day_q;
    hour_f = hour_q;
    min_f  = min_q;
    sec_f  = sec_q;
    case (phase_q)
      PH_SEARCH: begin
        if (data_byte_i == pre_char) pre_f = prefix_q + 3'd1;
        else                         pre_f = (data_byte_i == "D") ? 3'd1 : 3'd0;
        if (pre_f == 3'd5) begin
          ph_f  = PH_WEEK;
          tok_f = 2'd0;
        end
      end
      PH_WEEK: begin
        if (is_ws) begin
          if (tok_q != 2'd0) ph_f = PH_BAD;
        end else if (tok_q == 2'd2) begin
          ph_f  = PH_COMMA;
          tok_f = 2'd0;
        end else begin
          tok_f = tok_q + 2'd1;
        end
      end
      PH_COMMA: begin
        if (data_byte_i == ",") begin
          ph_f = PH_DAY;
          dc_f = 3'd0;
        end else begin
          ph_f = PH_BAD;
        end
      end
      PH_DAY: begin
        if (num_bad) ph_f = PH_BAD;
        if (num_take) begin
          dc_f  = dc_q + 3'd1;
          day_f = acc_new;
        end
        // Day done: this byte opens the month token unless it is whitespace
        if (num_fin) begin
          ph_f  = PH_MON;
          tok_f = 2'd0;
          mt_f  = 24'd0;
          if (!is_ws) begin
            mt_f  = {data_byte_i, 16'd0};
            tok_f = 2'd1;
          end
        end
      end
      PH_MON: begin
        if (is_ws) begin
          if (tok_q != 2'd0) begin
            ph_f = PH_YEAR;
            dc_f = 3'd0;
          end
        end else begin
          case (tok_q)
            2'd0:    mt_f[23:16] = data_byte_i;
            2'd1:    mt_f[15:8]  = data_byte_i;
            default: mt_f[7:0]   = data_byte_i;
          endcase
          tok_f = tok_q + 2'd1;
          if (tok_q == 2'd2) begin
            ph_f  = PH_YEAR;
            dc_f  = 3'd0;
            tok_f = 2'd0;
          end
        end
      end
      PH_YEAR: begin
        if (num_bad) ph_f = PH_BAD;
        if (num_take) begin
          dc_f = dc_q + 3'd1;
          if (dc_q < 3'd2) yhi_f = acc_new;
          else             ylo_f = acc_new;
        end
        // Year done: this byte may only be whitespace before the hour
        if (num_fin) begin
          dc_f = 3'd0;
          ph_f = is_ws ? PH_HOUR : PH_BAD;
        end
      end
      PH_HOUR: begin
        if (num_bad) ph_f = PH_BAD;
        if (num_take) begin
          dc_f   = dc_q + 3'd1;
          hour_f = acc_new;
        end
        if (num_fin) begin
          dc_f = 3'd0;
          ph_f = (data_byte_i == ":") ? PH_MIN : PH_BAD;
        end
      end
      PH_COLON1: begin
        dc_f = 3'd0;
        ph_f = (data_byte_i == ":") ? PH_MIN : PH_BAD;
      end
      PH_MIN: begin
        if (num_bad) ph_f = PH_BAD;
        if (num_take) begin
          dc_f  = dc_q + 3'd1;
          min_f = acc_new;
        end
        if (num_fin) begin
          dc_f = 3'd0;
          ph_f = (data_byte_i == ":") ? PH_SEC : PH_BAD;
        end
      end
      PH_COLON2: begin
        dc_f = 3'd0;
        ph_f = (data_byte_i == ":") ? PH_SEC : PH_BAD;
      end
      PH_SEC: begin
        if (num_bad) ph_f = PH_BAD;
        if (num_take) begin
          dc_f  = dc_q + 3'd1;
          sec_f = acc_new;
        end
        if (num_fin) ph_f = PH_DONE;
      end
      default: begin
        ph_f = phase_q;
      end
    endcase
  end

  // State after this byte: a zero byte leaves the parse as it was
  always_comb begin
    ph_p   = is_zero ? phase_q : ph_f;
    mt_p   = is_zero ? mtext_q : mt_f;
    dc_p   = is_zero ? dc_q    : dc_f;
    yhi_p  = is_zero ? yhi_q   : yhi_f;
    ylo_p  = is_zero ? ylo_q   : ylo_f;
    day_p  = is_zero ? day_q   : day_f;
    hour_p = is_zero ? hour_q  : hour_f;
    min_p  = is_zero ? min_q   : min_f;
    sec_p  = is_zero ? sec_q   : sec_f;
  end

  // Build the parse record for the end of text
  always_comb begin
    q_push_o       = accept && !ended_q && (is_zero || last_i);
    q_rec_o.mtext  = mt_p;
    q_rec_o.yhi    = yhi_p;
    q_rec_o.ylo    = ylo_p;
    q_rec_o.day    = day_p;
    q_rec_o.hour   = hour_p;
    q_rec_o.minute = min_p;
    q_rec_o.second = sec_p;
    q_rec_o.offset = offset_i;
    if (ph_p == PH_SEARCH) begin
      q_rec_o.status = hdzs_pkg::ST_NO_PREFIX;
    end else if ((ph_p == PH_DONE) || ((ph_p == PH_SEC) && (dc_p == 3'd2))) begin
      q_rec_o.status = hdzs_pkg::ST_OK;
    end else begin
      q_rec_o.status = hdzs_pkg::ST_BAD_FORMAT;
    end
  end

  // Next register values: hold, advance, or clear on the final byte
  always_comb begin
    phase_d  = phase_q;
    prefix_d = prefix_q;
    tok_d    = tok_q;
    mtext_d  = mtext_q;
    dc_d     = dc_q;
    yhi_d    = yhi_q;
    ylo_d    = ylo_q;
    day_d    = day_q;
    hour_d   = hour_q;
    min_d    = min_q;
    sec_d    = sec_q;
    ended_d  = ended_q;
    if (accept) begin
      if (last_i) begin
        phase_d  = PH_SEARCH;
        prefix_d = 3'd0;
        tok_d    = 2'd0;
        mtext_d  = 24'd0;
        dc_d     = 3'd0;
        ended_d  = 1'b0;
      end else if (!ended_q) begin
        if (is_zero) begin
          ended_d = 1'b1;
        end else begin
          phase_d  = ph_f;
          prefix_d = pre_f;
          tok_d    = tok_f;
          mtext_d  = mt_f;
          dc_d     = dc_f;
          yhi_d    = yhi_f;
          ylo_d    = ylo_f;
          day_d    = day_f;
          hour_d   = hour_f;
          min_d    = min_f;
          sec_d    = sec_f;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      prefix_q <= 3'd0;
      tok_q    <= 2'd0;
      mtext_q  <= 24'd0;
      dc_q     <= 3'd0;
      ended_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      prefix_q <= prefix_d;
      tok_q    <= tok_d;
      mtext_q  <= mtext_d;
      dc_q     <= dc_d;
      ended_q  <= ended_d;
    end
  end

  // Number accumulators
  always_ff @(posedge clk_i) begin
    yhi_q  <= yhi_d;
    ylo_q  <= ylo_d;
    day_q  <= day_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    sec_q  <= sec_d;
  end

endmodule

/* rtl/core/hdzs_queue.sv */
// ----------------------------------------------------------------------------
// hdzs_queue
// Short first-in first-out queue of parse records between front and back.
// ----------------------------------------------------------------------------
module hdzs_queue #(
  parameter int unsigned Depth = hdzs_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hdzs_pkg::rec_t rec_i,
  input  logic           pop_i,
  output hdzs_pkg::rec_t rec_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

  hdzs_pkg::rec_t mem_q [Depth];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

endmodule

/* rtl/core/hdzs_back.sv */
// ----------------------------------------------------------------------------
// hdzs_back
// Result unit: decodes the month, adds the hour offset, carries whole days
// into the calendar one day per cycle and holds the result register.
// ----------------------------------------------------------------------------
module hdzs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  hdzs_pkg::rec_t q_rec_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic [13:0]    year_o,
  output logic [3:0]     month_o,
  output logic [6:0]     day_o,
  output logic [4:0]     hour_o,
  output logic [6:0]     minute_o,
  output logic [6:0]     second_o
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_LOOK  = 4'b0010,
    B_CARRY = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_e;

  bstate_e        state_q, state_d;
  hdzs_pkg::rec_t rec_q;
  hdzs_pkg::stat_e st_q;
  logic [3:0]     mon_q;
  logic [6:0]     cen_q, yy_q, d_q;
  logic [7:0]     h_q;

  logic           out_valid_q;
  logic [1:0]     status_q;
  logic [13:0]    year_q;
  logic [3:0]     month_q;
  logic [6:0]     day_q, minute_q, second_q;
  logic [4:0]     hour_q;

  logic           leap, out_free, carry;
  logic [4:0]     maxd;
  logic [6:0]     d_inc;
  logic [3:0]     mon_dec;

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign mon_dec  = hdzs_pkg::month_decode(rec_q.mtext);
  assign leap     = (yy_q == 7'd0) ? (cen_q[1:0] == 2'd0) : (yy_q[1:0] == 2'd0);
  assign maxd     = hdzs_pkg::month_days(mon_q, leap);
  assign d_inc    = d_q + 7'd1;
  assign carry    = (st_q == hdzs_pkg::ST_OK) && (h_q >= hdzs_pkg::HOURS_PER_DAY);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!q_empty_i) state_d = B_LOOK;
      B_LOOK:  state_d = B_CARRY;
      B_CARRY: if (!carry) state_d = B_EMIT;
      B_EMIT:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == B_EMIT) && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
    end
  end

  // Working registers: take the record, then carry one day per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) rec_q <= q_rec_i;
      end
      B_LOOK: begin
        if ((rec_q.status == hdzs_pkg::ST_OK) && (mon_dec == 4'd0)) begin
          st_q <= hdzs_pkg::ST_BAD_MONTH;
        end else begin
          st_q <= rec_q.status;
        end
        mon_q <= mon_dec;
        cen_q <= rec_q.yhi;
        yy_q  <= rec_q.ylo;
        d_q   <= rec_q.day;
        h_q   <= {1'b0, rec_q.hour} + {3'd0, rec_q.offset};
      end
      B_CARRY: begin
        if (carry) begin
          h_q <= h_q - hdzs_pkg::HOURS_PER_DAY;
          if (d_inc > {2'd0, maxd}) begin
            d_q <= 7'd1;
            if (mon_q == 4'd12) begin
              mon_q <= 4'd1;
              if (yy_q == 7'd99) begin
                yy_q  <= 7'd0;
                cen_q <= cen_q + 7'd1;
              end else begin
                yy_q <= yy_q + 7'd1;
              end
            end else begin
              mon_q <= mon_q + 4'd1;
            end
          end else begin
            d_q <= d_inc;
          end
        end
      end
      default: begin
        rec_q <= rec_q;
      end
    endcase
  end

  // Result register, all date and time fields zero on error
  always_ff @(posedge clk_i) begin
    if ((state_q == B_EMIT) && out_free) begin
      status_q <= st_q;
      if (st_q == hdzs_pkg::ST_OK) begin
        year_q   <= 14'(14'(cen_q) * 14'd100) + 14'(yy_q);
        month_q  <= mon_q;
        day_q    <= d_q;
        hour_q   <= h_q[4:0];
        minute_q <= rec_q.minute;
        second_q <= rec_q.second;
      end else begin
        year_q   <= 14'd0;
        month_q  <= 4'd0;
        day_q    <= 7'd0;
        hour_q   <= 5'd0;
        minute_q <= 7'd0;
        second_q <= 7'd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign year_o      = year_q;
  assign month_o     = month_q;
  assign day_o       = day_q;
  assign hour_o      = hour_q;
  assign minute_o    = minute_q;
  assign second_o    = second_q;

endmodule

/* rtl/core/hdzs_checker.sv */
// ----------------------------------------------------------------------------
// hdzs_checker
// Port-level checks of the date parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hdzs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [13:0] year_o,
  input logic [3:0]  month_o,
  input logic [6:0]  day_o,
  input logic [4:0]  hour_o,
  input logic [6:0]  minute_o,
  input logic [6:0]  second_o
);

  // A failed parse carries no date
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != hdzs_pkg::ST_OK)) |->
      (year_o == 14'd0 && month_o == 4'd0 && day_o == 7'd0 &&
       hour_o == 5'd0 && minute_o == 7'd0 && second_o == 7'd0))
    else $error("error result carries non-zero fields");

  // A good result has a real month and a carried hour
  a_ok_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == hdzs_pkg::ST_OK)) |->
      (month_o >= 4'd1 && month_o <= 4'd12 && hour_o < 5'd24))
    else $error("good result out of range");

  // A stalled result holds its valid flag, status, date and hour
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(year_o) && $stable(month_o) &&
       $stable(day_o) && $stable(hour_o)))
    else $error("stalled result changed");

endmodule

bind http_date_parse_zone_shift hdzs_checker u_hdzs_checker (.*);
